// ===== src/landmark_predictive_smoother_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LANDMARK_PREDICTIVE_SMOOTHER_MACROS_SVH
`define LANDMARK_PREDICTIVE_SMOOTHER_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define LPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that also holds across reset.
`define LPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lps_pkg.sv =====
package lps_pkg;

   localparam int POINTS_DEF = 21;

   localparam int TICK_W     = 32;
   localparam int IDX_W      = 5;
   localparam int COORD_W    = 16;
   localparam int HORIZON_W  = 10;
   localparam int DELTA_W    = 16;
   localparam int ALPHA_W    = 9;
   localparam int FACTOR_W   = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // horizon * 256
   localparam int DIVIDEND_W = HORIZON_W + 8;
   // shared multiplier: signed operand a, unsigned operand b, signed accumulator
   localparam int OPA_W      = COORD_W + 2;
   localparam int MAC_W      = OPA_W + FACTOR_W + 1;
   // current coordinate plus scaled delta
   localparam int PSUM_W     = 24;

   localparam logic [COORD_W-1:0] ONE_Q15   = 16'd32768;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   localparam logic [HORIZON_W-1:0] HORIZON_RST = 10'd25;
   localparam logic [DELTA_W-1:0]   DELTA_RST   = 16'd2621;
   localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 9'd192;
   localparam logic [FACTOR_W-1:0]  CAP_RST     = 11'd384;

   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP     = 2'd3;

   typedef struct packed {
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y;
      logic [COORD_W-1:0] avg_x;
      logic [COORD_W-1:0] avg_y;
   } hist_word_type;

   localparam int HIST_W = $bits(hist_word_type);

   typedef struct packed {
      logic                    en;
      logic                    accum;
      logic signed [OPA_W-1:0] op_a;
      logic [FACTOR_W-1:0]     op_b;
   } mac_cmd_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [TICK_W-1:0]     divisor;
   } div_req_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_DIV  = 8'b0000_0010,
      S_MD   = 8'b0000_0100,
      S_PR   = 8'b0000_1000,
      S_M1   = 8'b0001_0000,
      S_M2   = 8'b0010_0000,
      S_SUM  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

endpackage

// ===== src/lps_ram.sv =====
module lps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 21,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lps_div.sv =====
module lps_div (
   input  logic                             clock,
   input  logic                             reset,
   input  lps_pkg::div_req_type             div_req,
   output logic                             div_done,
   output logic [lps_pkg::DIVIDEND_W-1:0]   quotient
);

   localparam int W     = lps_pkg::DIVIDEND_W;
   localparam int TW    = lps_pkg::TICK_W;
   localparam int CNT_W = $clog2(W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [TW-1:0]    rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [TW-1:0]    dsr_ff, dsr_in;

   logic [TW:0]      trial;
   logic [TW:0]      diff;
   logic             fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = !diff[TW];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[TW-1:0] : trial[TW-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/lps_mac.sv =====
module lps_mac (
   input  logic                                clock,
   input  lps_pkg::mac_cmd_type                mac_cmd,
   output logic signed [lps_pkg::MAC_W-1:0]    mac_acc
);

   localparam int MW = lps_pkg::MAC_W;

   logic signed [MW-1:0] opa_ext;
   logic signed [MW-1:0] opb_ext;
   logic signed [MW-1:0] prod;
   logic signed [MW-1:0] acc_ff, acc_in;

   assign opa_ext = MW'(mac_cmd.op_a);
   assign opb_ext = MW'($signed({1'b0, mac_cmd.op_b}));
   assign prod    = opa_ext * opb_ext;

   always_comb begin
      acc_in = acc_ff;
      if (mac_cmd.en) begin
         acc_in = mac_cmd.accum ? acc_ff + prod : prod;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign mac_acc = acc_ff;

endmodule

// ===== src/landmark_predictive_smoother.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  frame_time_ms, point_index, restart, coord_x/y/z
// rsp       out        rsp_valid / rsp_ready  out_index, smooth_x, smooth_y, out_z
// csr       in         csr_we (no wait)       csr_index, csr_wdata
//
// A tracked point runs, per axis, five steps on the one shared multiplier
// (delta times factor, prediction, two blend products, sum), then the result load.
// Point 0 of a tracked frame first waits for the bit-serial interval divider.
// Copied points (first, restart or out-of-range) go straight to the result load.
// Synchronous active-high reset; the history memory has no reset.
// A result waiting on rsp_ready holds only the final load; the next item is taken.
module landmark_predictive_smoother #(
   parameter int POINTS = lps_pkg::POINTS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [lps_pkg::TICK_W-1:0]              req_frame_time_ms,
   input  logic [lps_pkg::IDX_W-1:0]               req_point_index,
   input  logic                                    req_restart,
   input  logic [lps_pkg::COORD_W-1:0]             req_coord_x,
   input  logic [lps_pkg::COORD_W-1:0]             req_coord_y,
   input  logic signed [lps_pkg::COORD_W-1:0]      req_coord_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [lps_pkg::IDX_W-1:0]               rsp_out_index,
   output logic [lps_pkg::COORD_W-1:0]             rsp_smooth_x,
   output logic [lps_pkg::COORD_W-1:0]             rsp_smooth_y,
   output logic signed [lps_pkg::COORD_W-1:0]      rsp_out_z,
   input  logic                                    csr_we,
   input  logic [lps_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int AW     = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int CW     = lps_pkg::COORD_W;
   localparam int OW     = lps_pkg::OPA_W;
   localparam int PW     = lps_pkg::PSUM_W;
   localparam int FW     = lps_pkg::FACTOR_W;
   localparam int CMP_W  = lps_pkg::IDX_W + 2;
   localparam logic [CMP_W-1:0]     POINTS_V = CMP_W'(POINTS);
   localparam logic signed [PW-1:0] P_MAX    = PW'(lps_pkg::ONE_Q15);

   // configuration
   logic [lps_pkg::HORIZON_W-1:0] horizon_ff;
   logic [lps_pkg::DELTA_W-1:0]   delta_ff;
   logic [lps_pkg::ALPHA_W-1:0]   alpha_ff;
   logic [FW-1:0]                 cap_ff;

   // control state
   lps_pkg::state_type            state_ff, state_in;
   logic                          axis_ff, axis_in;
   logic [lps_pkg::TICK_W-1:0]    last_tick_ff, last_tick_in;
   logic [FW-1:0]                 factor_ff, factor_in;
   logic                          hist_valid_ff, hist_valid_in;
   logic                          init_frame_ff, init_frame_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;

   // item payload
   logic [lps_pkg::IDX_W-1:0]     idx_ff;
   logic [CW-1:0]                 cx_ff, cy_ff;
   logic signed [CW-1:0]          z_ff;
   logic                          in_range_ff;
   logic [CW-1:0]                 p_ff;
   logic [CW-1:0]                 sx_ff, sy_ff;

   logic [lps_pkg::IDX_W-1:0]     rsp_idx_ff;
   logic [CW-1:0]                 rsp_x_ff, rsp_y_ff;
   logic signed [CW-1:0]          rsp_z_ff;

   logic                          accept;
   logic                          req_in_range;
   logic                          point0;
   logic                          fresh;
   logic [lps_pkg::TICK_W-1:0]    dt;
   logic [CW-1:0]                 cx_sat, cy_sat;

   lps_pkg::div_req_type          div_req;
   logic                          div_done;
   logic [lps_pkg::DIVIDEND_W-1:0] quotient;
   logic [FW-1:0]                 factor_capped;

   lps_pkg::mac_cmd_type          mac_cmd;
   logic signed [lps_pkg::MAC_W-1:0] mac_acc;

   logic                          ram_wr_en;
   logic [lps_pkg::HIST_W-1:0]    ram_rd_data;
   lps_pkg::hist_word_type        rd_word;
   lps_pkg::hist_word_type        wr_word;

   logic [CW-1:0]                 cur, prev, avg;
   logic signed [OW-1:0]          diff, lim, d_clamp;
   logic signed [PW-1:0]          p_sum;
   logic [CW-1:0]                 p_sat;
   logic [lps_pkg::ALPHA_W-1:0]   alpha_eff;
   logic [CW-1:0]                 blend;
   logic                          tracked;
   logic [CW-1:0]                 out_x, out_y;

   assign req_ready    = (state_ff == lps_pkg::S_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = {2'b00, req_point_index} < POINTS_V;
   assign point0       = (req_point_index == '0);
   assign fresh        = req_restart || !hist_valid_ff;
   assign dt           = req_frame_time_ms - last_tick_ff;
   assign cx_sat       = (req_coord_x > lps_pkg::ONE_Q15) ? lps_pkg::ONE_Q15 : req_coord_x;
   assign cy_sat       = (req_coord_y > lps_pkg::ONE_Q15) ? lps_pkg::ONE_Q15 : req_coord_y;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= lps_pkg::HORIZON_RST;
         delta_ff   <= lps_pkg::DELTA_RST;
         alpha_ff   <= lps_pkg::ALPHA_RST;
         cap_ff     <= lps_pkg::CAP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            lps_pkg::CSR_HORIZON: horizon_ff <= csr_wdata[lps_pkg::HORIZON_W-1:0];
            lps_pkg::CSR_DELTA:   delta_ff   <= csr_wdata[lps_pkg::DELTA_W-1:0];
            lps_pkg::CSR_ALPHA:   alpha_ff   <= csr_wdata[lps_pkg::ALPHA_W-1:0];
            lps_pkg::CSR_CAP:     cap_ff     <= csr_wdata[FW-1:0];
            default: ;
         endcase
      end
   end

   lps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   assign factor_capped = (quotient > lps_pkg::DIVIDEND_W'(cap_ff)) ? cap_ff : quotient[FW-1:0];

   lps_mac u_mac (
      .clock   (clock),
      .mac_cmd (mac_cmd),
      .mac_acc (mac_acc)
   );

   lps_ram #(
      .WIDTH (lps_pkg::HIST_W),
      .DEPTH (POINTS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(idx_ff)),
      .wr_data (wr_word),
      .rd_en   (accept && req_in_range),
      .rd_addr (AW'(req_point_index)),
      .rd_data (ram_rd_data)
   );

   assign rd_word = ram_rd_data;

   // per-axis datapath around the shared multiplier
   assign cur  = axis_ff ? cy_ff : cx_ff;
   assign prev = axis_ff ? rd_word.prev_y : rd_word.prev_x;
   assign avg  = axis_ff ? rd_word.avg_y : rd_word.avg_x;
   assign diff = $signed({2'b00, cur}) - $signed({2'b00, prev});
   assign lim  = $signed({2'b00, delta_ff});

   always_comb begin
      d_clamp = diff;
      if (diff > lim) begin
         d_clamp = lim;
      end else if (diff < -lim) begin
         d_clamp = -lim;
      end
   end

   // floor of product / 256 is the arithmetic shift
   assign p_sum = $signed({8'b0, cur}) + PW'(mac_acc >>> 8);

   always_comb begin
      if (p_sum[PW-1]) begin
         p_sat = '0;
      end else if (p_sum > P_MAX) begin
         p_sat = lps_pkg::ONE_Q15;
      end else begin
         p_sat = p_sum[CW-1:0];
      end
   end

   assign alpha_eff = (alpha_ff > lps_pkg::ALPHA_ONE) ? lps_pkg::ALPHA_ONE : alpha_ff;
   assign blend     = mac_acc[CW+7:8];

   assign tracked = in_range_ff && !init_frame_ff;
   assign out_x   = tracked ? sx_ff : cx_ff;
   assign out_y   = tracked ? sy_ff : cy_ff;

   assign wr_word.prev_x = cx_ff;
   assign wr_word.prev_y = cy_ff;
   assign wr_word.avg_x  = out_x;
   assign wr_word.avg_y  = out_y;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      last_tick_in   = last_tick_ff;
      factor_in      = factor_ff;
      hist_valid_in  = hist_valid_ff;
      init_frame_in  = init_frame_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_load       = 1'b0;
      ram_wr_en      = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = {horizon_ff, 8'b0};
      div_req.divisor  = (dt == '0) ? lps_pkg::TICK_W'(1) : dt;
      mac_cmd.en     = 1'b0;
      mac_cmd.accum  = 1'b0;
      mac_cmd.op_a   = d_clamp;
      mac_cmd.op_b   = factor_ff;

      unique case (state_ff)
         lps_pkg::S_IDLE: begin
            axis_in = 1'b0;
            if (accept) begin
               if (point0) begin
                  last_tick_in  = req_frame_time_ms;
                  hist_valid_in = 1'b1;
                  if (fresh) begin
                     init_frame_in = 1'b1;
                     state_in      = lps_pkg::S_DONE;
                  end else begin
                     init_frame_in = 1'b0;
                     div_req.start = 1'b1;
                     state_in      = lps_pkg::S_DIV;
                  end
               end else if (init_frame_ff || !req_in_range) begin
                  state_in = lps_pkg::S_DONE;
               end else begin
                  state_in = lps_pkg::S_MD;
               end
            end
         end
         lps_pkg::S_DIV: begin
            if (div_done) begin
               factor_in = factor_capped;
               state_in  = lps_pkg::S_MD;
            end
         end
         lps_pkg::S_MD: begin
            mac_cmd.en = 1'b1;
            state_in   = lps_pkg::S_PR;
         end
         lps_pkg::S_PR: begin
            state_in = lps_pkg::S_M1;
         end
         lps_pkg::S_M1: begin
            mac_cmd.en   = 1'b1;
            mac_cmd.op_a = $signed({2'b00, p_ff});
            mac_cmd.op_b = FW'(alpha_eff);
            state_in     = lps_pkg::S_M2;
         end
         lps_pkg::S_M2: begin
            mac_cmd.en    = 1'b1;
            mac_cmd.accum = 1'b1;
            mac_cmd.op_a  = $signed({2'b00, avg});
            mac_cmd.op_b  = FW'(lps_pkg::ALPHA_ONE - alpha_eff);
            state_in      = lps_pkg::S_SUM;
         end
         lps_pkg::S_SUM: begin
            if (axis_ff) begin
               state_in = lps_pkg::S_DONE;
            end else begin
               axis_in  = 1'b1;
               state_in = lps_pkg::S_MD;
            end
         end
         lps_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               ram_wr_en    = in_range_ff;
               state_in     = lps_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lps_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lps_pkg::S_IDLE;
         axis_ff       <= 1'b0;
         last_tick_ff  <= '0;
         factor_ff     <= '0;
         hist_valid_ff <= 1'b0;
         init_frame_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         last_tick_ff  <= last_tick_in;
         factor_ff     <= factor_in;
         hist_valid_ff <= hist_valid_in;
         init_frame_ff <= init_frame_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff      <= req_point_index;
         cx_ff       <= cx_sat;
         cy_ff       <= cy_sat;
         z_ff        <= req_coord_z;
         in_range_ff <= req_in_range;
      end
      if (state_ff == lps_pkg::S_PR) begin
         p_ff <= p_sat;
      end
      if (state_ff == lps_pkg::S_SUM) begin
         if (axis_ff) begin
            sy_ff <= blend;
         end else begin
            sx_ff <= blend;
         end
      end
      if (rsp_load) begin
         rsp_idx_ff <= idx_ff;
         rsp_x_ff   <= out_x;
         rsp_y_ff   <= out_y;
         rsp_z_ff   <= z_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_idx_ff;
   assign rsp_smooth_x  = rsp_x_ff;
   assign rsp_smooth_y  = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;

endmodule

// ===== src/lps_checker.sv =====
`include "landmark_predictive_smoother_macros.svh"

module lps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [lps_pkg::IDX_W-1:0]           rsp_out_index,
   input logic [lps_pkg::COORD_W-1:0]         rsp_smooth_x,
   input logic [lps_pkg::COORD_W-1:0]         rsp_smooth_y,
   input logic signed [lps_pkg::COORD_W-1:0]  rsp_out_z
);

   // reset leaves the block ready with no result pending
   `LPS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (req_ready && !rsp_valid), "not idle after reset")

   // a transfer on req starts work that blocks the next one
   `LPS_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready right after a req transfer")

   // a new result only appears at the end of an item's work
   `LPS_ASSERT(a_rsp_from_work, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "result without work")

   `LPS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_index) && $stable(rsp_smooth_x) && $stable(rsp_smooth_y) && $stable(rsp_out_z)), "stalled result changed")

endmodule

bind landmark_predictive_smoother lps_checker u_lps_checker (.*);

// ===== tb/sv/lps_prediction_checker.sv =====
`timescale 1ns / 1ps
module lps_prediction_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [lps_pkg::TICK_W-1:0]          req_frame_time_ms,
   input  logic [lps_pkg::IDX_W-1:0]           req_point_index,
   input  logic                                req_restart,
   input  logic [lps_pkg::COORD_W-1:0]         req_coord_x,
   input  logic [lps_pkg::COORD_W-1:0]         req_coord_y,
   input  logic signed [lps_pkg::COORD_W-1:0]  req_coord_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [lps_pkg::IDX_W-1:0]           rsp_out_index,
   input  logic [lps_pkg::COORD_W-1:0]         rsp_smooth_x,
   input  logic [lps_pkg::COORD_W-1:0]         rsp_smooth_y,
   input  logic signed [lps_pkg::COORD_W-1:0]  rsp_out_z,
   input  logic                                csr_we,
   input  logic [lps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                  fail_count,
   output int                                  outstanding
);
   import lps_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } smoothed_point_type;

   smoothed_point_type due_points [$];

   // register copies
   int horizon_cfg;
   int delta_cfg;
   int alpha_cfg;
   int cap_cfg;

   // tracking state
   logic [COORD_W-1:0] prev_x [POINTS_DEF];
   logic [COORD_W-1:0] prev_y [POINTS_DEF];
   logic [COORD_W-1:0] avg_x  [POINTS_DEF];
   logic [COORD_W-1:0] avg_y  [POINTS_DEF];
   logic [TICK_W-1:0]  last_tick;
   int                 frame_factor;
   bit                 hist_valid;
   bit                 init_frame;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // clamp the change, extrapolate, saturate, then blend into the running average
   function automatic logic [COORD_W-1:0] track_axis(input int cur, input int prev,
                                                     input int avg);
      int d;
      int p;
      int a;
      d = cur - prev;
      if (d > delta_cfg) d = delta_cfg;
      if (d < -delta_cfg) d = -delta_cfg;
      p = cur + ((d * frame_factor) >>> 8);
      if (p < 0) p = 0;
      if (p > int'(ONE_Q15)) p = int'(ONE_Q15);
      a = (alpha_cfg > 256) ? 256 : alpha_cfg;
      return COORD_W'((a * p + (256 - a) * avg) / 256);
   endfunction

   task automatic check_field(input string what, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : step
      smoothed_point_type want;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [TICK_W-1:0]  dt;
      longint             span;
      longint             ratio;
      int                 idx;

      if (reset) begin
         horizon_cfg  = int'(HORIZON_RST);
         delta_cfg    = int'(DELTA_RST);
         alpha_cfg    = int'(ALPHA_RST);
         cap_cfg      = int'(CAP_RST);
         for (int i = 0; i < POINTS_DEF; i++) begin
            prev_x[i] = '0;
            prev_y[i] = '0;
            avg_x[i]  = '0;
            avg_y[i]  = '0;
         end
         last_tick    = '0;
         frame_factor = 0;
         hist_valid   = 1'b0;
         init_frame   = 1'b1;
         due_points.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HORIZON: horizon_cfg = int'(csr_wdata[HORIZON_W-1:0]);
               CSR_DELTA:   delta_cfg   = int'(csr_wdata[DELTA_W-1:0]);
               CSR_ALPHA:   alpha_cfg   = int'(csr_wdata[ALPHA_W-1:0]);
               CSR_CAP:     cap_cfg     = int'(csr_wdata[FACTOR_W-1:0]);
               default: ;
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            if (due_points.size() == 0) begin
               $display("%0t: unexpected result transfer, index %0d", $time, rsp_out_index);
               fail_count++;
            end else begin
               want = due_points.pop_front();
               check_field("out_index", COORD_W'(want.index), COORD_W'(rsp_out_index));
               check_field("smooth_x", want.x, rsp_smooth_x);
               check_field("smooth_y", want.y, rsp_smooth_y);
               check_field("out_z", want.z, rsp_out_z);
            end
         end

         if (req_valid && req_ready) begin
            cx  = (req_coord_x > ONE_Q15) ? ONE_Q15 : req_coord_x;
            cy  = (req_coord_y > ONE_Q15) ? ONE_Q15 : req_coord_y;
            idx = int'(req_point_index);
            if (idx == 0) begin
               if (req_restart || !hist_valid) begin
                  init_frame = 1'b1;
                  hist_valid = 1'b1;
                  last_tick  = req_frame_time_ms;
               end else begin
                  dt        = req_frame_time_ms - last_tick;
                  last_tick = req_frame_time_ms;
                  if (dt == 0) dt = 1;
                  span  = longint'(dt);
                  ratio = (longint'(horizon_cfg) * 256) / span;
                  if (ratio > longint'(cap_cfg)) ratio = longint'(cap_cfg);
                  frame_factor = int'(ratio);
                  init_frame   = 1'b0;
               end
            end
            want.index = req_point_index;
            want.x     = cx;
            want.y     = cy;
            want.z     = req_coord_z;
            if (idx < POINTS_DEF) begin
               if (init_frame) begin
                  prev_x[idx] = cx;
                  prev_y[idx] = cy;
                  avg_x[idx]  = cx;
                  avg_y[idx]  = cy;
               end else begin
                  want.x      = track_axis(int'(cx), int'(prev_x[idx]), int'(avg_x[idx]));
                  want.y      = track_axis(int'(cy), int'(prev_y[idx]), int'(avg_y[idx]));
                  avg_x[idx]  = want.x;
                  avg_y[idx]  = want.y;
                  prev_x[idx] = cx;
                  prev_y[idx] = cy;
               end
            end
            due_points.push_back(want);
         end
         outstanding = due_points.size();
      end
   end

endmodule

// ===== tb/sv/tb_landmark_predictive_smoother.sv =====
`timescale 1ns / 1ps
module tb_landmark_predictive_smoother;
   import lps_pkg::*;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [TICK_W-1:0]           req_frame_time_ms;
   logic [IDX_W-1:0]            req_point_index;
   logic                        req_restart;
   logic [COORD_W-1:0]          req_coord_x;
   logic [COORD_W-1:0]          req_coord_y;
   logic signed [COORD_W-1:0]   req_coord_z;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [IDX_W-1:0]            rsp_out_index;
   logic [COORD_W-1:0]          rsp_smooth_x;
   logic [COORD_W-1:0]          rsp_smooth_y;
   logic signed [COORD_W-1:0]   rsp_out_z;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_wdata;

   int fail_count;
   int outstanding;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_rsp    = 1'b0;
   bit hold_done   = 1'b0;
   int sent        = 0;

   logic [TICK_W-1:0]  tick;
   logic [COORD_W-1:0] base_x [POINTS_DEF];
   logic [COORD_W-1:0] base_y [POINTS_DEF];

   landmark_predictive_smoother dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_time_ms (req_frame_time_ms),
      .req_point_index   (req_point_index),
      .req_restart       (req_restart),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_index     (rsp_out_index),
      .rsp_smooth_x      (rsp_smooth_x),
      .rsp_smooth_y      (rsp_smooth_y),
      .rsp_out_z         (rsp_out_z),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   lps_prediction_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_time_ms (req_frame_time_ms),
      .req_point_index   (req_point_index),
      .req_restart       (req_restart),
      .req_coord_x       (req_coord_x),
      .req_coord_y       (req_coord_y),
      .req_coord_z       (req_coord_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_index     (rsp_out_index),
      .rsp_smooth_x      (rsp_smooth_x),
      .rsp_smooth_y      (rsp_smooth_y),
      .rsp_out_z         (rsp_out_z),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #10_000_000;
      $display("FAIL landmark_predictive_smoother");
      $finish;
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_point(input logic [TICK_W-1:0] t, input logic [IDX_W-1:0] idx,
                             input logic rst, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_frame_time_ms <= t;
      req_point_index   <= idx;
      req_restart       <= rst;
      req_coord_x       <= x;
      req_coord_y       <= y;
      req_coord_z       <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // move a coordinate a little, now and then jump to an edge or anywhere
   function automatic logic [COORD_W-1:0] drift(input logic [COORD_W-1:0] cur);
      int v;
      case ($urandom_range(15))
         0: return COORD_W'($urandom);
         1: return ONE_Q15;
         2: return '0;
         default: begin
            v = (cur > ONE_Q15) ? int'(ONE_Q15) : int'(cur);
            v = v + int'($urandom_range(6000)) - 3000;
            if (v < 0) v = 0;
            if (v > int'(ONE_Q15)) v = int'(ONE_Q15);
            return COORD_W'(v);
         end
      endcase
   endfunction

   task automatic send_frame(input bit fresh);
      int                npts;
      logic [TICK_W-1:0] dt;
      case ($urandom_range(9))
         0: dt = '0;
         1: dt = $urandom;
         2: dt = $urandom_range(1, 5);
         default: dt = $urandom_range(10, 120);
      endcase
      tick = fresh ? $urandom : tick + dt;
      npts = ($urandom_range(3) == 0) ? $urandom_range(1, POINTS_DEF) : POINTS_DEF;
      for (int i = 0; i < npts; i++) begin
         base_x[i] = drift(base_x[i]);
         base_y[i] = drift(base_y[i]);
         // restart only matters on point 0
         send_point(tick, IDX_W'(i), (i == 0) ? fresh : 1'($urandom_range(1)),
                    base_x[i], base_y[i], COORD_W'($urandom));
      end
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] h, input logic [CSR_DATA_W-1:0] d,
                                 input logic [CSR_DATA_W-1:0] a, input logic [CSR_DATA_W-1:0] c);
      logic [CSR_IDX_W-1:0]  regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      regs = '{CSR_HORIZON, CSR_DELTA, CSR_ALPHA, CSR_CAP};
      vals = '{h, d, a, c};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int target;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_frame_time_ms = '0;
      req_point_index   = '0;
      req_restart       = 1'b0;
      req_coord_x       = '0;
      req_coord_y       = '0;
      req_coord_z       = '0;
      csr_we            = 1'b0;
      csr_index         = CSR_HORIZON;
      csr_wdata         = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // a point before any point 0 is copied
      send_point(32'h0, 5'd7, 1'b0, 16'hFFFF, 16'h0000, 16'h8000);

      // first frame: history not valid yet, tick close to wrapping
      tick = 32'hFFFF_FFF0;
      for (int i = 0; i < POINTS_DEF; i++) begin
         base_x[i] = i[0] ? ONE_Q15 : 16'd0;
         base_y[i] = i[0] ? 16'd0 : ONE_Q15;
      end
      base_x[POINTS_DEF-1] = 16'hFFFF;
      base_y[POINTS_DEF-1] = 16'h7FFF;
      for (int i = 0; i < POINTS_DEF; i++)
         send_point(tick, IDX_W'(i), 1'b0, base_x[i], base_y[i],
                    i[0] ? 16'h7FFF : 16'h8000);

      // tracked frame across the tick wrap, full-scale moves hit the clamp
      tick = tick + 32'h20;
      send_point(tick, 5'd0, 1'b0, 16'd0, 16'd0, 16'h8000);
      send_point(tick, 5'd1, 1'b1, 16'd0, ONE_Q15, 16'h7FFF);
      send_point(tick, 5'd25, 1'b0, 16'hFFFF, 16'h8001, 16'h1234);
      // same tick again: zero interval
      send_point(tick, 5'd0, 1'b0, 16'd100, 16'd32000, 16'h0000);

      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) begin
            drain();
            case (ph)
               1: apply_settings(16'd1000, 16'd32768, 16'd256, 16'd1024);
               2: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
               3: apply_settings(16'h03FF, 16'hFFFF, 16'h01FF, 16'h07FF);
               4: apply_settings(CSR_DATA_W'(HORIZON_RST), CSR_DATA_W'(DELTA_RST),
                                 CSR_DATA_W'(ALPHA_RST), CSR_DATA_W'(CAP_RST));
               5: apply_settings(16'd1, 16'd100, 16'd128, 16'd256);
               default: apply_settings(CSR_DATA_W'($urandom_range(1000)),
                                       CSR_DATA_W'($urandom_range(32768)),
                                       CSR_DATA_W'($urandom_range(256)),
                                       CSR_DATA_W'($urandom_range(1024)));
            endcase
         end
         target = sent + 200;
         while (sent < target) begin
            if (sent < 475) begin
               tx_idle_pct = 6;
               rx_idle_pct = 86;
            end else if (sent < 950) begin
               tx_idle_pct = 86;
               rx_idle_pct = 6;
            end else begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               hold_rsp    = 1'b1;
            end
            case ($urandom_range(19))
               0: send_point($urandom, IDX_W'($urandom_range(31)), 1'($urandom_range(1)),
                             COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
               1: send_frame(1'b1);
               default: send_frame(1'b0);
            endcase
         end
      end

      drain();
      if (fail_count == 0)
         $display("PASS landmark_predictive_smoother");
      else
         $display("FAIL landmark_predictive_smoother");
      $finish;
   end

endmodule
